// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the time string converter.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/a2e_pkg.sv =====
// Shared types and constants for the time string to epoch converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package a2e_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned YearW     = 14;
  localparam int unsigned FieldW    = 7;
  localparam int unsigned PosW      = 5;
  localparam int unsigned EpochW    = 39;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CharW-1:0]  CharZ      = 8'h5A;
  localparam logic [CharW-1:0]  CharZero   = 8'h30;
  localparam logic [CharW-1:0]  CharNine   = 8'h39;
  localparam logic [YearW-1:0]  YearPivot  = 14'd49;
  localparam logic [YearW-1:0]  Century19  = 14'd1900;
  localparam logic [YearW-1:0]  Century20  = 14'd2000;
  localparam logic [YearW-1:0]  EpochYear  = 14'd1970;
  localparam logic [YearW-1:0]  ClampYear  = 14'd2038;
  localparam logic [EpochW-1:0] ClampValue = 39'd2145914603;
  localparam logic [EpochW-1:0] EpochMax   = 39'd274877906943;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_Z      = 3'd2,
    ST_BAD_MONTH = 3'd3,
    ST_EARLY     = 3'd4
  } a2e_status_e;

  // One parsed string, handed from the parser to the date arithmetic.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic              gen;
    a2e_status_e       status;
  } a2e_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } a2e_fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_DAYS,
    BK_HOURS,
    BK_MINS,
    BK_SECS,
    BK_OUT
  } a2e_back_state_e;

  // Days in the months before the given one, non-leap year.
  function automatic logic [8:0] a2e_days_before(input logic [FieldW-1:0] month);
    logic [8:0] d;
    unique case (month)
      7'd2:    d = 9'd31;
      7'd3:    d = 9'd59;
      7'd4:    d = 9'd90;
      7'd5:    d = 9'd120;
      7'd6:    d = 9'd151;
      7'd7:    d = 9'd181;
      7'd8:    d = 9'd212;
      7'd9:    d = 9'd243;
      7'd10:   d = 9'd273;
      7'd11:   d = 9'd304;
      7'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/a2e_front.sv =====
// Character parser: accepts one character per cycle while the queue has room
// and builds the date fields; the last character pushes one job. Uses a2e_pkg.
`default_nettype none

module a2e_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [a2e_pkg::CharW-1:0]   char_i,
  input  wire logic                        gen_i,
  input  wire logic                        last_i,
  input  wire a2e_pkg::a2e_fifo_stat_t     fifo_stat_i,
  output      logic                        push_o,
  output      a2e_pkg::a2e_job_t           job_o
);
  import a2e_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic              ended_q, ended_d;
  logic              z_q, z_d;
  logic              stopped_q, stopped_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [FieldW-1:0] month_q, month_d;
  logic [FieldW-1:0] day_q, day_d;
  logic [FieldW-1:0] hour_q, hour_d;
  logic [FieldW-1:0] minute_q, minute_d;

  logic              accept;
  logic [PosW-1:0]   ylen;
  logic [PosW-1:0]   rel;
  logic              in_year;
  logic              in_tail;
  logic              start;
  logic              is_digit;
  logic              wr;
  logic [FieldW-1:0] small_cur;
  logic [YearW-1:0]  base;
  logic [17:0]       prod;
  logic [YearW-1:0]  new_val;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ylen     = gen_i ? 5'd4 : 5'd2;
    rel      = pos_q - ylen;
    in_year  = pos_q < ylen;
    in_tail  = !in_year && (rel < 5'd8);
    start    = in_year ? (pos_q == '0) : !rel[0];
    is_digit = (char_i >= CharZero) && (char_i <= CharNine);
    unique case (rel[2:1])
      2'd0:    small_cur = month_q;
      2'd1:    small_cur = day_q;
      2'd2:    small_cur = hour_q;
      default: small_cur = minute_q;
    endcase
    base    = start ? '0 : (in_year ? year_q : {{(YearW-FieldW){1'b0}}, small_cur});
    prod    = 18'(base) * 18'd10 + 18'(char_i[3:0]);
    wr      = start || (!stopped_q && is_digit);
    new_val = (is_digit && (start || !stopped_q)) ? prod[YearW-1:0] : '0;

    pos_d     = pos_q;
    ended_d   = ended_q;
    z_d       = z_q;
    stopped_d = stopped_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;

    if (!ended_q) begin
      if (char_i == '0) begin
        ended_d = 1'b1;
      end else begin
        if (char_i == CharZ) begin
          z_d = 1'b1;
        end
        if (in_year || in_tail) begin
          stopped_d = (start ? 1'b0 : stopped_q) || !is_digit;
          if (wr) begin
            if (in_year) begin
              year_d = new_val;
            end else begin
              unique case (rel[2:1])
                2'd0:    month_d  = new_val[FieldW-1:0];
                2'd1:    day_d    = new_val[FieldW-1:0];
                2'd2:    hour_d   = new_val[FieldW-1:0];
                default: minute_d = new_val[FieldW-1:0];
              endcase
            end
          end
        end
        if (pos_q != '1) begin
          pos_d = pos_q + 5'd1;
        end
      end
    end

    push_o       = accept && last_i;
    job_o.year   = year_d;
    job_o.month  = month_d;
    job_o.day    = day_d;
    job_o.hour   = hour_d;
    job_o.minute = minute_d;
    job_o.gen    = gen_i;
    priority if (pos_d < (gen_i ? 5'd12 : 5'd10)) begin
      job_o.status = ST_SHORT;
    end else if (gen_i && !z_d) begin
      job_o.status = ST_NO_Z;
    end else begin
      job_o.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ended_q   <= 1'b0;
      z_q       <= 1'b0;
      stopped_q <= 1'b0;
      year_q    <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      minute_q  <= '0;
    end else if (accept) begin
      if (last_i) begin
        // clear parse state for the next string
        pos_q     <= '0;
        ended_q   <= 1'b0;
        z_q       <= 1'b0;
        stopped_q <= 1'b0;
        year_q    <= '0;
        month_q   <= '0;
        day_q     <= '0;
        hour_q    <= '0;
        minute_q  <= '0;
      end else begin
        pos_q     <= pos_d;
        ended_q   <= ended_d;
        z_q       <= z_d;
        stopped_q <= stopped_d;
        year_q    <= year_d;
        month_q   <= month_d;
        day_q     <= day_d;
        hour_q    <= hour_d;
        minute_q  <= minute_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/a2e_fifo.sv =====
// Short register queue of parsed jobs between the parser and the arithmetic.
// Uses a2e_pkg for the job type and the status struct.
`default_nettype none

module a2e_fifo #(
  parameter int unsigned Depth = a2e_pkg::FifoDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire a2e_pkg::a2e_job_t        job_i,
  input  wire logic                     pop_i,
  output      a2e_pkg::a2e_job_t        job_o,
  output      a2e_pkg::a2e_fifo_stat_t  stat_o
);
  import a2e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  a2e_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/a2e_back.sv =====
// Date arithmetic sequencer: turns one parsed job into seconds since 1970
// over a few steps and holds the result in an output register. Uses a2e_pkg.
`default_nettype none

module a2e_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clamp_i,
  input  wire a2e_pkg::a2e_job_t             job_i,
  input  wire a2e_pkg::a2e_fifo_stat_t       fifo_stat_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [a2e_pkg::EpochW-1:0]    epoch_o,
  output      a2e_pkg::a2e_status_e          status_o
);
  import a2e_pkg::*;

  localparam int unsigned DaysW = 25;
  localparam int unsigned HrsW  = 31;
  localparam int unsigned MinsW = 37;
  localparam int unsigned SecsW = 43;

  a2e_back_state_e state_q, state_d;

  logic [YearW-1:0]  year_q, year_d;
  logic [FieldW-1:0] month_q, month_d;
  logic [FieldW-1:0] day_q, day_d;
  logic [FieldW-1:0] hour_q, hour_d;
  logic [FieldW-1:0] minute_q, minute_d;
  logic [11:0]       quart_q, quart_d;
  logic [7:0]        q100_q, q100_d;
  logic [7:0]        q25y_q, q25y_d;
  logic [22:0]       y365_q, y365_d;
  logic signed [DaysW-1:0] days_q, days_d;
  logic signed [HrsW-1:0]  hrs_q, hrs_d;
  logic signed [MinsW-1:0] mins_q, mins_d;
  logic [EpochW-1:0] res_epoch_q, res_epoch_d;
  a2e_status_e       res_status_q, res_status_d;

  logic              out_valid_q, out_valid_d;
  logic [EpochW-1:0] out_epoch_q, out_epoch_d;
  a2e_status_e       out_status_q, out_status_d;

  logic [YearW-1:0]  year_full;
  logic [YearW-1:0]  ym1;
  logic [22:0]       prod_a, prod_b;
  logic [12:0]       cent_chk;
  logic              leap;
  logic signed [SecsW-1:0] secs;

  assign out_valid_o = out_valid_q;
  assign epoch_o     = out_epoch_q;
  assign status_o    = out_status_q;

  always_comb begin
    state_d      = state_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    quart_d      = quart_q;
    q100_d       = q100_q;
    q25y_d       = q25y_q;
    y365_d       = y365_q;
    days_d       = days_q;
    hrs_d        = hrs_q;
    mins_d       = mins_q;
    res_epoch_d  = res_epoch_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_epoch_d  = out_epoch_q;
    out_status_d = out_status_q;
    pop_o        = 1'b0;

    year_full = job_i.gen ? job_i.year :
                job_i.year + ((job_i.year > YearPivot) ? Century19 : Century20);
    ym1       = year_q - 14'd1;
    // divide by 25 through a reciprocal multiply, exact below 4096
    prod_a    = 23'(ym1[YearW-1:2]) * 23'd1311;
    prod_b    = 23'(year_q[YearW-1:2]) * 23'd1311;
    cent_chk  = 13'(q25y_q) * 13'd25;
    leap      = (year_q[1:0] == 2'b00) &&
                ((cent_chk != 13'(year_q[YearW-1:2])) || (q25y_q[1:0] == 2'b00));
    secs      = SecsW'(mins_q) * 43'sd60;

    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o       = 1'b1;
          res_epoch_d = '0;
          year_d      = year_full;
          month_d     = job_i.month;
          day_d       = job_i.day;
          hour_d      = job_i.hour;
          minute_d    = job_i.minute;
          state_d     = BK_OUT;
          priority if (job_i.status != ST_OK) begin
            res_status_d = job_i.status;
          end else if (clamp_i && (year_full >= ClampYear)) begin
            res_status_d = ST_OK;
            res_epoch_d  = ClampValue;
          end else if ((job_i.month < 7'd1) || (job_i.month > 7'd12)) begin
            res_status_d = ST_BAD_MONTH;
          end else if (year_full < EpochYear) begin
            res_status_d = ST_EARLY;
          end else begin
            res_status_d = ST_OK;
            state_d      = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        quart_d = ym1[YearW-1:2];
        q100_d  = prod_a[22:15];
        q25y_d  = prod_b[22:15];
        y365_d  = 23'(year_q - EpochYear) * 23'd365;
        state_d = BK_DAYS;
      end
      BK_DAYS: begin
        // leap days since 1970 cancel the 477 leap years through 1969
        days_d = $signed(DaysW'(y365_q)) + $signed(DaysW'(quart_q))
               - $signed(DaysW'(q100_q)) + $signed(DaysW'(q100_q[7:2]))
               - 25'sd477 + $signed(DaysW'(a2e_days_before(month_q)))
               + $signed(DaysW'((month_q > 7'd2) && leap))
               + $signed(DaysW'(day_q)) - 25'sd1;
        state_d = BK_HOURS;
      end
      BK_HOURS: begin
        hrs_d   = HrsW'(days_q) * 31'sd24 + $signed(HrsW'(hour_q));
        state_d = BK_MINS;
      end
      BK_MINS: begin
        mins_d  = MinsW'(hrs_q) * 37'sd60 + $signed(MinsW'(minute_q));
        state_d = BK_SECS;
      end
      BK_SECS: begin
        if (secs > $signed(SecsW'(EpochMax))) begin
          res_epoch_d = EpochMax;
        end else begin
          res_epoch_d = secs[EpochW-1:0];
        end
        state_d = BK_OUT;
      end
      BK_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_epoch_d  = res_epoch_q;
          out_status_d = res_status_q;
          state_d      = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q       <= year_d;
    month_q      <= month_d;
    day_q        <= day_d;
    hour_q       <= hour_d;
    minute_q     <= minute_d;
    quart_q      <= quart_d;
    q100_q       <= q100_d;
    q25y_q       <= q25y_d;
    y365_q       <= y365_d;
    days_q       <= days_d;
    hrs_q        <= hrs_d;
    mins_q       <= mins_d;
    res_epoch_q  <= res_epoch_d;
    res_status_q <= res_status_d;
    out_epoch_q  <= out_epoch_d;
    out_status_q <= out_status_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/asn1_time_string_to_epoch.sv =====
// ASN.1 UTCTime / GeneralizedTime string to seconds since 1970.
//
// Input stream: one character per transaction. tdata is the character,
// tuser selects GeneralizedTime (1) or UTCTime (0), tlast marks the final
// character of a string. A NUL character ends the string; later characters
// up to tlast are ignored. The parser takes one character per cycle unless stalled.
// Output stream: one transaction per string, on its tlast character. tdata
// carries the signed epoch seconds and the status code (0 ok, 1 too short,
// 2 no Z, 3 bad month, 4 year before 1970; seconds are 0 on error).
// A good date runs the job queue and every sequencer step before output tvalid;
// an error or clamped result goes from the job pop straight to the output load.
// The sequencer steps are job pop, divide, day sum, three scaling steps and output
// load, so strings of 10 or more characters stream without gaps.
// A two-entry job queue sits between parser and sequencer; input tready
// drops only when that queue is full: while the receiver holds output tready
// low, or on a run of strings shorter than the sequencer time per string.
// The output register holds its transaction until taken.
// Reset clears the parser, the queue, the output and the clamp register.
// cfg_we_i writes the clamp enable from cfg_wdata_i; write it while idle.
// Depends on a2e_pkg, a2e_front, a2e_fifo, a2e_back and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module asn1_time_string_to_epoch #(
  parameter int unsigned FifoDepth = a2e_pkg::FifoDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [a2e_pkg::CharW-1:0]      s_axis_tdata,   // [7:0] char_byte
  input  wire logic                           s_axis_tuser,   // [0] is_generalized
  input  wire logic                           s_axis_tlast,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [38:0] epoch_seconds, [41:39] status, [47:42] zero
  output      logic [a2e_pkg::OutDataW-1:0]   m_axis_tdata
);
  import a2e_pkg::*;

  logic           clamp_q;
  logic           fe_push;
  logic           be_pop;
  a2e_job_t       push_job;
  a2e_job_t       head_job;
  a2e_fifo_stat_t fifo_stat;
  logic [EpochW-1:0] epoch;
  a2e_status_e    status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b0;
    end else if (cfg_we_i) begin
      clamp_q <= cfg_wdata_i;
    end
  end

  a2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .char_i      (s_axis_tdata),
    .gen_i       (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .fifo_stat_i (fifo_stat),
    .push_o      (fe_push),
    .job_o       (push_job)
  );

  a2e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_push),
    .job_i  (push_job),
    .pop_i  (be_pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  a2e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clamp_i     (clamp_q),
    .job_i       (head_job),
    .fifo_stat_i (fifo_stat),
    .pop_o       (be_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .epoch_o     (epoch),
    .status_o    (status)
  );

  assign m_axis_tdata = {{(OutDataW-EpochW-StatusW){1'b0}}, status, epoch};

  `ASSERT_IMPLY(a_push_has_room, clk_i, rst_ni, fe_push, !fifo_stat.full)
  `ASSERT_IMPLY(a_pop_has_job, clk_i, rst_ni, be_pop, !fifo_stat.empty)
  `ASSERT_NEXT(a_push_lands, clk_i, rst_ni, fe_push, !fifo_stat.empty)
  `ASSERT_IMPLY(a_error_zero_secs, clk_i, rst_ni, m_axis_tvalid && (status != ST_OK), epoch == '0)

endmodule

`default_nettype wire
